// ===== src/stereo_dither_quantizer_macros.svh =====
// Assertion macros for the checked module, sdq_ctrl.
// Each expects clk and rst in the scope where it is used.
`ifndef STEREO_DITHER_QUANTIZER_MACROS_SVH
`define STEREO_DITHER_QUANTIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdq assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SDQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdq assertion failed");

`endif

// ===== src/sdq_pkg.sv =====
`default_nettype none
package sdq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_BITS   = 40;
  localparam int OUT_BITS  = 16;
  localparam int LCG_W     = 31;

  localparam int SUM_W   = IN_BITS + 1;
  localparam int WHOLE_W = SUM_W - FRAC_BITS + 1;

  localparam logic [LCG_W-1:0] LCG_MUL  = 31'd1103515245;
  localparam logic [LCG_W-1:0] LCG_ADD  = 31'd12345;
  localparam logic [LCG_W-1:0] LCG_SEED = 31'h16BA2118;

  // Two generator steps folded into one: x'' = x*MUL^2 + (ADD*MUL + ADD)
  localparam logic [63:0] LCG_MUL2_FULL = 64'(LCG_MUL) * 64'(LCG_MUL);
  localparam logic [63:0] LCG_ADD2_FULL = 64'(LCG_ADD) * 64'(LCG_MUL) + 64'(LCG_ADD);
  localparam logic [LCG_W-1:0] LCG_MUL2 = LCG_MUL2_FULL[LCG_W-1:0];
  localparam logic [LCG_W-1:0] LCG_ADD2 = LCG_ADD2_FULL[LCG_W-1:0];

  // Offset-binary bounds of the rounded integer part
  localparam logic [WHOLE_W-1:0] Q_ZERO = WHOLE_W'(1) << (IN_BITS - 1 - FRAC_BITS);
  localparam logic [WHOLE_W-1:0] Q_LO   = Q_ZERO - WHOLE_W'(32768);
  localparam logic [WHOLE_W-1:0] Q_HI   = Q_ZERO + WHOLE_W'(32767);
  localparam logic [FRAC_BITS-1:0] Q_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic capture;
    logic mul;
    logic upd;
    logic sum;
    logic load_out;
  } sdq_cmd_t;

  typedef struct packed {
    logic dither_en;
  } sdq_status_t;

endpackage
`default_nettype wire

// ===== src/sdq_if.sv =====
`default_nettype none
interface sdq_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [sdq_pkg::IN_BITS-1:0] left_sample;
  logic signed [sdq_pkg::IN_BITS-1:0] right_sample;
  logic                              end_of_block;

  modport source (output valid, left_sample, right_sample, end_of_block, input ready);
  modport sink   (input valid, left_sample, right_sample, end_of_block, output ready);
endinterface

interface sdq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_frame;
  logic        last_out;

  modport source (output valid, packed_frame, last_out, input ready);
  modport sink   (input valid, packed_frame, last_out, output ready);
endinterface
`default_nettype wire

// ===== src/sdq_datapath.sv =====
`default_nettype none
module sdq_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire sdq_pkg::sdq_cmd_t                  cmd,
  output sdq_pkg::sdq_status_t                    status,
  input  wire logic                               cfg_write_en,
  input  wire logic                               cfg_write_data,
  input  wire logic signed [sdq_pkg::IN_BITS-1:0] left_sample,
  input  wire logic signed [sdq_pkg::IN_BITS-1:0] right_sample,
  input  wire logic                               end_of_block,
  output logic [31:0]                             packed_frame,
  output logic                                    last_out
);

  logic                              dither_en;
  logic [sdq_pkg::LCG_W-1:0]         lcg_state;
  logic [sdq_pkg::LCG_W-1:0]         prod_r;
  logic [sdq_pkg::LCG_W-1:0]         prod_l;
  logic [sdq_pkg::IN_BITS-1:0]       left_q;
  logic [sdq_pkg::IN_BITS-1:0]       right_q;
  logic                              eob_q;
  logic [sdq_pkg::FRAC_BITS-1:0]     dither_r;
  logic [sdq_pkg::FRAC_BITS-1:0]     dither_l;
  logic [sdq_pkg::SUM_W-1:0]         sum_r;
  logic [sdq_pkg::SUM_W-1:0]         sum_l;
  logic [sdq_pkg::LCG_W-1:0]         state_r;
  logic [sdq_pkg::LCG_W-1:0]         state_l;
  logic [sdq_pkg::OUT_BITS-1:0]      q_r;
  logic [sdq_pkg::OUT_BITS-1:0]      q_l;

  function automatic logic [sdq_pkg::SUM_W-1:0] bias_add(
    input logic [sdq_pkg::IN_BITS-1:0]   raw,
    input logic [sdq_pkg::FRAC_BITS-1:0] dither
  );
    logic [sdq_pkg::IN_BITS-1:0] biased;
    begin
      biased = {~raw[sdq_pkg::IN_BITS-1], raw[sdq_pkg::IN_BITS-2:0]};
      bias_add = sdq_pkg::SUM_W'(biased) + sdq_pkg::SUM_W'(dither);
    end
  endfunction

  // Round to nearest even, clamp, convert offset binary back to int16
  function automatic logic [sdq_pkg::OUT_BITS-1:0] round_sat(
    input logic [sdq_pkg::SUM_W-1:0] sum
  );
    logic [sdq_pkg::FRAC_BITS-1:0] frac;
    logic [sdq_pkg::WHOLE_W-1:0]   whole;
    logic                          inc;
    logic [sdq_pkg::WHOLE_W-1:0]   diff;
    begin
      frac  = sum[sdq_pkg::FRAC_BITS-1:0];
      whole = sdq_pkg::WHOLE_W'(sum[sdq_pkg::SUM_W-1:sdq_pkg::FRAC_BITS]);
      inc   = (frac > sdq_pkg::Q_HALF) || ((frac == sdq_pkg::Q_HALF) && whole[0]);
      whole = whole + sdq_pkg::WHOLE_W'(inc);
      if (whole < sdq_pkg::Q_LO) begin
        whole = sdq_pkg::Q_LO;
      end else if (whole > sdq_pkg::Q_HI) begin
        whole = sdq_pkg::Q_HI;
      end
      diff = whole - sdq_pkg::Q_LO;
      round_sat = diff[sdq_pkg::OUT_BITS-1:0] ^ {1'b1, {(sdq_pkg::OUT_BITS-1){1'b0}}};
    end
  endfunction

  assign state_r = prod_r + sdq_pkg::LCG_ADD;
  assign state_l = prod_l + sdq_pkg::LCG_ADD2;
  assign q_r     = round_sat(sum_r);
  assign q_l     = round_sat(sum_l);

  assign status.dither_en = dither_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      dither_en <= 1'b1;
      lcg_state <= sdq_pkg::LCG_SEED;
    end else begin
      if (cfg_write_en) begin
        dither_en <= cfg_write_data;
      end
      // Left value is the second generator step, so it becomes the new state
      if (cmd.upd) begin
        lcg_state <= state_l;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      left_q   <= left_sample;
      right_q  <= right_sample;
      eob_q    <= end_of_block;
      dither_r <= '0;
      dither_l <= '0;
    end
    if (cmd.mul) begin
      prod_r <= lcg_state * sdq_pkg::LCG_MUL;
      prod_l <= lcg_state * sdq_pkg::LCG_MUL2;
    end
    if (cmd.upd) begin
      dither_r <= state_r[sdq_pkg::LCG_W-1 -: sdq_pkg::FRAC_BITS];
      dither_l <= state_l[sdq_pkg::LCG_W-1 -: sdq_pkg::FRAC_BITS];
    end
    if (cmd.sum) begin
      sum_r <= bias_add(right_q, dither_r);
      sum_l <= bias_add(left_q, dither_l);
    end
    if (cmd.load_out) begin
      packed_frame <= {q_r, q_l};
      last_out     <= eob_q;
    end
  end

endmodule
`default_nettype wire

// ===== src/sdq_ctrl.sv =====
`default_nettype none
`include "stereo_dither_quantizer_macros.svh"
module sdq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire sdq_pkg::sdq_status_t status,
  output sdq_pkg::sdq_cmd_t         cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_UPD   = 5'b00100,
    ST_SUM   = 5'b01000,
    ST_ROUND = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   in_xfer;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd.capture  = 1'b0;
    cmd.mul      = 1'b0;
    cmd.upd      = 1'b0;
    cmd.sum      = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = status.dither_en ? ST_MUL : ST_SUM;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `SDQ_ASSERT_NEXT(a_accept_path, in_xfer, (state == ST_MUL) || (state == ST_SUM))
  `SDQ_ASSERT_NEXT(a_mul_then_upd, state == ST_MUL, state == ST_UPD)
  `SDQ_ASSERT_NEXT(a_stall_holds, (state == ST_ROUND) && out_valid && !out_ready,
                   (state == ST_ROUND) && out_valid)
  `SDQ_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid)
  `SDQ_ASSERT_SAME(a_load_when_free, cmd.load_out, (state == ST_ROUND) && out_free)

endmodule
`default_nettype wire

// ===== src/stereo_dither_quantizer.sv =====
// Stereo dither quantizer: turns one frame of fixed-point stereo samples
// (16 fractional bits) into one packed int16 pair, right in bits 31:16.
// Channels: in_ch carries left_sample, right_sample and end_of_block;
// out_ch carries packed_frame and last_out. Each moves on a valid/ready
// transfer. cfg_write_en/cfg_write_data set dither_enable; write it idle.
// Steps: with dither on, a captured input passes generator multiply,
// generator update, sum and round before the result is valid; with
// dither off the generator steps are skipped.
// Frames: the controller handles one frame at a time and takes no new
// input until the last one is in the output register. Both generator
// steps come from the old state in parallel (second step uses the
// squared multiplier).
// Reset: generator state returns to its seed, dither is enabled, the
// output register is empty.
// Stall: a finished result sits in the output register; the next input
// is still taken and processed, and it waits in the round stage until
// the output register has been read.
`default_nettype none
module stereo_dither_quantizer (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_write_en,
  input  wire logic  cfg_write_data,
  sdq_in_if.sink     in_ch,
  sdq_out_if.source  out_ch
);

  sdq_pkg::sdq_cmd_t    cmd;
  sdq_pkg::sdq_status_t status;

  sdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sdq_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .left_sample    (in_ch.left_sample),
    .right_sample   (in_ch.right_sample),
    .end_of_block   (in_ch.end_of_block),
    .packed_frame   (out_ch.packed_frame),
    .last_out       (out_ch.last_out)
  );

endmodule
`default_nettype wire
